// ===== hdl/rms_deviation_accumulator_defines.svh =====
// Assertion macros for the RMS deviation accumulator.
// Depends on nothing; included by the files that carry assertions.
`ifndef RMS_DEVIATION_ACCUMULATOR_DEFINES_SVH
`define RMS_DEVIATION_ACCUMULATOR_DEFINES_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define RDA_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Condition must never be seen at a clock edge outside reset.
`define RDA_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define RDA_ASSERT(label, clk, rst_n, prop)
`define RDA_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

// ===== hdl/rda_pkg.sv =====
// Shared types and constants of the RMS deviation accumulator.
// Request and result payload structs, configuration register indexes.
package rda_pkg;

  // Field widths of the request and result payloads
  localparam int unsigned SAMPLE_WIDTH   = 24;
  localparam int unsigned COLUMN_WIDTH   = 12;
  localparam int unsigned RMS_WIDTH      = 24;
  localparam int unsigned ELEMENT_WIDTH  = 32;

  // Defaults for the top-level parameters
  localparam int unsigned COLUMN_COUNT_DEF = 4096;
  localparam int unsigned COUNT_WIDTH_DEF  = 32;

  // Configuration port
  localparam int unsigned CFG_INDEX_WIDTH = 2;
  localparam int unsigned CFG_DATA_WIDTH  = 13;
  localparam int unsigned WIN_WIDTH_BITS  = 13;
  localparam int unsigned WIN_INDEX_BITS  = 12;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_WINDOW_MODE  = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_WINDOW_WIDTH = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_WINDOW_INDEX = 2'd2;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample_value;
    logic signed [SAMPLE_WIDTH-1:0] reference_value;
    logic [COLUMN_WIDTH-1:0]        column;
    logic                           last;
  } rda_in_t;

  typedef struct packed {
    logic [RMS_WIDTH-1:0]     rms_value;
    logic [ELEMENT_WIDTH-1:0] element_count;
    logic                     no_elements;
    logic                     sum_saturated;
  } rda_out_t;

endpackage

// ===== hdl/rms_deviation_accumulator.sv =====
// RMS deviation accumulator: squared-difference sum, divide and root.
// Depends on rda_pkg and rms_deviation_accumulator_defines.svh.
//
//   channel  direction  handshake                 payload
//   in       request    in_valid_i / in_stall_o   in_data_i   (rda_in_t)
//   out      result     out_valid_o / out_stall_i out_data_o  (rda_out_t)
//   cfg      write      cfg_we_i                  cfg_index_i, cfg_wdata_i
//
// A request that is not last passes through capture, square and accumulate.
// A last request adds 64 restoring divide steps and 32 root steps on one
// shared subtractor, plus a load of the result register in the load state;
// an empty set skips the divide and root. Reset clears the sum, count,
// saturation flag, window mode and window index at once; window width is 1.
// A waiting result does not block new requests; only a second finished
// result waits in the load state until the first one is taken.
`include "rms_deviation_accumulator_defines.svh"

module rms_deviation_accumulator
  import rda_pkg::*;
#(
  parameter int unsigned COLUMN_COUNT = COLUMN_COUNT_DEF,
  parameter int unsigned COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  rda_in_t                    in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output rda_out_t                   out_data_o,
  input  logic                       cfg_we_i,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index_i,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_wdata_i
);

  localparam int unsigned DIFF_W  = SAMPLE_WIDTH + 1;
  localparam int unsigned SQ_W    = 2 * SAMPLE_WIDTH + 1;
  localparam int unsigned SUM_W   = 64;
  localparam int unsigned ROOT_W  = SUM_W / 2;
  localparam int unsigned SUB_W   = ROOT_W + 3;
  localparam int unsigned STEP_W  = 6;
  localparam int unsigned START_W = WIN_WIDTH_BITS + WIN_INDEX_BITS;
  localparam int unsigned STOP_W  = START_W + 1;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SQUARE = 6'b000010,
    ST_ADD    = 6'b000100,
    ST_DIV    = 6'b001000,
    ST_ROOT   = 6'b010000,
    ST_FIN    = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic                      mode_q;
  logic [WIN_WIDTH_BITS-1:0] win_width_q;
  logic [WIN_INDEX_BITS-1:0] win_index_q;

  // Accumulator state
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic                   sat_q, sat_d;

  // Per-request datapath registers
  logic signed [DIFF_W-1:0] diff_q;
  logic [SQ_W-1:0]          sq_q;
  logic [COLUMN_WIDTH-1:0]  col_q;
  logic                     last_q;
  logic [START_W-1:0]       win_start_q;
  logic [SUB_W-1:0]         rem_q;
  logic [ROOT_W-1:0]        root_q;
  logic [STEP_W-1:0]        step_q;

  // Result register
  logic     out_valid_q;
  rda_out_t out_data_q;

  logic in_take, out_take, fin_load;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_take     = in_valid_i && !in_stall_o;
  assign out_take    = out_valid_q && !out_stall_i;
  assign fin_load    = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Square the registered difference
  logic signed [2*DIFF_W-1:0] sq_full;
  assign sq_full = (2*DIFF_W)'(diff_q) * (2*DIFF_W)'(diff_q);

  // Window test against the registered window start
  logic [STOP_W-1:0] win_stop;
  logic              col_hit;
  assign win_stop = STOP_W'(win_start_q) + STOP_W'(win_width_q);
  assign col_hit  = !mode_q ||
                    ((STOP_W'(col_q) >= STOP_W'(win_start_q)) &&
                     (STOP_W'(col_q) < win_stop) &&
                     (32'(col_q) < COLUMN_COUNT));

  // Saturating accumulate
  logic [SUM_W:0] sum_ext;
  assign sum_ext = {1'b0, sum_q} + (SUM_W + 1)'(sq_q);

  // Shared subtractor for divide and root steps
  logic [SUB_W-1:0] sub_a, sub_b, sub_diff;
  logic             sub_borrow;

  always_comb begin
    case (state_q)
      ST_DIV: begin
        sub_a = {rem_q[SUB_W-2:0], sum_q[SUM_W-1]};
        sub_b = SUB_W'(count_q);
      end
      ST_ROOT: begin
        sub_a = {rem_q[SUB_W-3:0], sum_q[SUM_W-1 -: 2]};
        sub_b = SUB_W'({root_q, 2'b01});
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  assign {sub_borrow, sub_diff} = {1'b0, sub_a} - {1'b0, sub_b};

  // Clamp the root to the result width
  logic [RMS_WIDTH-1:0] rms_clamped;
  assign rms_clamped = (|root_q[ROOT_W-1:RMS_WIDTH]) ? '1 : root_q[RMS_WIDTH-1:0];

  // Sequencer and accumulator next state
  always_comb begin
    state_d = state_q;
    sum_d   = sum_q;
    count_d = count_q;
    sat_d   = sat_q;
    case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          state_d = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        state_d = ST_ADD;
      end
      ST_ADD: begin
        if (col_hit) begin
          if (sum_ext[SUM_W]) begin
            sum_d = '1;
            sat_d = 1'b1;
          end else begin
            sum_d = sum_ext[SUM_W-1:0];
            if (&sum_ext[SUM_W-1:0]) begin
              sat_d = 1'b1;
            end
          end
          if (!(&count_q)) begin
            count_d = count_q + 1'b1;
          end
        end
        if (!last_q) begin
          state_d = ST_IDLE;
        end else if (count_d == '0) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        // Shift the quotient into the sum register
        sum_d = {sum_q[SUM_W-2:0], !sub_borrow};
        if (step_q == '0) begin
          state_d = ST_ROOT;
        end
      end
      ST_ROOT: begin
        // Drain two radicand bits per step
        sum_d = {sum_q[SUM_W-3:0], 2'b00};
        if (step_q == '0) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (fin_load) begin
          sum_d   = '0;
          count_d = '0;
          sat_d   = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control and accumulator registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      count_q     <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
      mode_q      <= 1'b0;
      win_width_q <= WIN_WIDTH_BITS'(1);
      win_index_q <= '0;
    end else begin
      state_q <= state_d;
      sum_q   <= sum_d;
      count_q <= count_d;
      sat_q   <= sat_d;
      if (fin_load) begin
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
      // Configuration writes; unknown indexes are dropped
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_WINDOW_MODE:  mode_q      <= cfg_wdata_i[0];
          CFG_WINDOW_WIDTH: win_width_q <= cfg_wdata_i[WIN_WIDTH_BITS-1:0];
          CFG_WINDOW_INDEX: win_index_q <= cfg_wdata_i[WIN_INDEX_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          diff_q <= DIFF_W'(in_data_i.sample_value) - DIFF_W'(in_data_i.reference_value);
          col_q  <= in_data_i.column;
          last_q <= in_data_i.last;
        end
      end
      ST_SQUARE: begin
        sq_q        <= sq_full[SQ_W-1:0];
        win_start_q <= START_W'(win_width_q) * START_W'(win_index_q);
      end
      ST_ADD: begin
        rem_q  <= '0;
        root_q <= '0;
        step_q <= STEP_W'(SUM_W - 1);
      end
      ST_DIV: begin
        if (step_q == '0) begin
          rem_q  <= '0;
          step_q <= STEP_W'(ROOT_W - 1);
        end else begin
          rem_q  <= sub_borrow ? sub_a : sub_diff;
          step_q <= step_q - 1'b1;
        end
      end
      ST_ROOT: begin
        rem_q  <= sub_borrow ? sub_a : sub_diff;
        root_q <= {root_q[ROOT_W-2:0], !sub_borrow};
        step_q <= step_q - 1'b1;
      end
      ST_FIN: begin
        if (fin_load) begin
          out_data_q.rms_value     <= rms_clamped;
          out_data_q.element_count <= ELEMENT_WIDTH'(count_q);
          out_data_q.no_elements   <= (count_q == '0);
          out_data_q.sum_saturated <= sat_q;
        end
      end
      default: ;
    endcase
  end

  // Count only grows while accumulating
  `RDA_ASSERT(a_count_grows, clk_i, rst_ni, (state_q == ST_ADD) |=> (count_q >= $past(count_q)))
  // A saturated sum stays pinned at its maximum until the divide starts
  `RDA_ASSERT(a_sat_pinned, clk_i, rst_ni, (sat_q && (state_q == ST_IDLE || state_q == ST_SQUARE)) |-> (&sum_q))
  // A result appears only out of the load state
  `RDA_ASSERT(a_out_from_fin, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == ST_FIN))
  // An empty set reports a zero root and zero count
  `RDA_ASSERT_NEVER(a_empty_zero, clk_i, rst_ni, out_valid_q && out_data_q.no_elements && ((out_data_q.rms_value != '0) || (out_data_q.element_count != '0)))

endmodule
